>>> src/infix_integer_expression_evaluator_defines.svh
// Assertion helpers used by the checker.
`ifndef INFIX_INTEGER_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_INTEGER_EXPRESSION_EVALUATOR_DEFINES_SVH

// Checked outside reset only.
`define IIEE_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define IIEE_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/iiee_pkg.sv
`default_nettype none
package iiee_pkg;

  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_OR    = 8'd124;
  localparam logic [7:0] CH_XOR   = 8'd94;
  localparam logic [7:0] CH_AND   = 8'd38;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_PCT   = 8'd37;
  localparam logic [7:0] CH_LT    = 8'd60;
  localparam logic [7:0] CH_GT    = 8'd62;
  localparam logic [7:0] CH_EQ    = 8'd61;
  localparam logic [7:0] CH_BANG  = 8'd33;

  typedef enum logic [3:0] {
    OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE,
    OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD
  } op_t;

  typedef enum logic [2:0] {P_NONE, P_LT, P_GT, P_EQ, P_NE} pend_t;

  typedef enum logic [1:0] {CLS_EXPECT, CLS_SIGN, CLS_NUM, CLS_NUMSP} cls_t;

  typedef enum logic [1:0] {CS_MATCH, CS_FALLBACK, CS_CHAR} code_src_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_PROC, S_CMT, S_CMT_CHK, S_PUSH, S_RED, S_RED_A,
    S_RED_CAP, S_RED_EXE, S_RED_DIV, S_RED_WB, S_FIN, S_FIN_RD, S_FIN_OUT
  } state_t;

  typedef struct packed {
    logic      load_char;
    logic      set_err;
    logic      space_upd;
    logic      accum_upd;
    logic      set_sign;
    logic      end_opnd;
    logic      set_code;
    code_src_t code_src;
    logic      set_pend;
    logic      op_rd;
    logic      op_push;
    logic      rd_b;
    logic      rd_a;
    logic      cap_b;
    logic      cap_a;
    logic      alu;
    logic      div_start;
    logic      wb;
    logic      rd0;
    logic      out_load;
    logic      clr_state;
  } cmd_t;

  typedef struct packed {
    logic is_hash;
    logic is_space;
    logic is_digit;
    logic is_sign;
    logic is_binop;
    logic is_cmp1;
    logic pend_nz;
    logic pend_match;
    logic pend_ltgt;
    cls_t cls;
    logic err;
    logic red_bad;
    logic opr_empty;
    logic prec_ge;
    logic op_is_div;
    logic div_busy;
    logic cnt_is1;
    logic out_busy;
  } sts_t;

  // C precedence, larger binds tighter
  function automatic logic [3:0] prec_of(input op_t op);
    logic [3:0] p;
    case (op)
      OP_OR:                      p = 4'd1;
      OP_XOR:                     p = 4'd2;
      OP_AND:                     p = 4'd3;
      OP_EQ, OP_NE:               p = 4'd4;
      OP_LT, OP_GT, OP_LE, OP_GE: p = 4'd5;
      OP_SHL, OP_SHR:             p = 4'd6;
      OP_ADD, OP_SUB:             p = 4'd7;
      default:                    p = 4'd8;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

>>> src/iiee_ram.sv
`default_nettype none
module iiee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/iiee_ctrl.sv
`default_nettype none
module iiee_ctrl
  import iiee_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   resume_r, resume_nxt;   // reprocess the char after a fallback commit
  logic   fin_r, fin_nxt;         // reductions belong to the final sweep

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      resume_r <= 1'b0;
      fin_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      resume_r <= resume_nxt;
      fin_r    <= fin_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    resume_nxt = resume_r;
    fin_nxt    = fin_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_char = 1'b1;
          state_nxt     = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_hash) begin
          if (sts.err) begin
            state_nxt = S_FIN_OUT;
          end else if (sts.pend_nz || sts.cls == CLS_EXPECT || sts.cls == CLS_SIGN) begin
            cmd.set_err = 1'b1;
            state_nxt   = S_FIN_OUT;
          end else begin
            cmd.end_opnd = 1'b1;
            fin_nxt      = 1'b1;
            state_nxt    = S_FIN;
          end
        end else if (sts.err) begin
          state_nxt = S_IDLE;
        end else if (sts.is_space) begin
          cmd.space_upd = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.pend_nz) begin
          if (sts.pend_match) begin
            cmd.set_code = 1'b1;
            cmd.code_src = CS_MATCH;
            resume_nxt   = 1'b0;
            fin_nxt      = 1'b0;
            state_nxt    = S_CMT;
          end else if (sts.pend_ltgt) begin
            cmd.set_code = 1'b1;
            cmd.code_src = CS_FALLBACK;
            resume_nxt   = 1'b1;
            fin_nxt      = 1'b0;
            state_nxt    = S_CMT;
          end else begin
            cmd.set_err = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        state_nxt = S_IDLE;
        if (sts.err) begin
          state_nxt = S_IDLE;
        end else if (sts.is_digit) begin
          if (sts.cls == CLS_NUMSP) cmd.set_err = 1'b1;
          else cmd.accum_upd = 1'b1;
        end else if (sts.cls == CLS_EXPECT) begin
          if (sts.is_sign) cmd.set_sign = 1'b1;
          else cmd.set_err = 1'b1;
        end else if (sts.cls == CLS_SIGN) begin
          cmd.set_err = 1'b1;
        end else if (sts.is_binop) begin
          cmd.end_opnd = 1'b1;
          cmd.set_code = 1'b1;
          cmd.code_src = CS_CHAR;
          resume_nxt   = 1'b0;
          fin_nxt      = 1'b0;
          state_nxt    = S_CMT;
        end else if (sts.is_cmp1) begin
          cmd.end_opnd = 1'b1;
          cmd.set_pend = 1'b1;
        end else begin
          cmd.set_err = 1'b1;
        end
      end
      S_CMT: begin
        if (!sts.err && !sts.opr_empty) begin
          cmd.op_rd = 1'b1;
          state_nxt = S_CMT_CHK;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_CMT_CHK: begin
        state_nxt = sts.prec_ge ? S_RED : S_PUSH;
      end
      S_PUSH: begin
        cmd.op_push = 1'b1;
        state_nxt   = resume_r ? S_PROC : S_IDLE;
        resume_nxt  = 1'b0;
      end
      S_RED: begin
        if (sts.red_bad) begin
          cmd.set_err = 1'b1;
          state_nxt   = fin_r ? S_FIN : S_CMT;
        end else begin
          cmd.rd_b  = 1'b1;
          cmd.op_rd = 1'b1;
          state_nxt = S_RED_A;
        end
      end
      S_RED_A: begin
        cmd.cap_b = 1'b1;
        cmd.rd_a  = 1'b1;
        state_nxt = S_RED_CAP;
      end
      S_RED_CAP: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_RED_EXE;
      end
      S_RED_EXE: begin
        if (sts.op_is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_RED_DIV;
        end else begin
          cmd.alu   = 1'b1;
          state_nxt = S_RED_WB;
        end
      end
      S_RED_DIV: begin
        if (!sts.div_busy) state_nxt = S_RED_WB;
      end
      S_RED_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = fin_r ? S_FIN : S_CMT;
      end
      S_FIN: begin
        if (!sts.err && !sts.opr_empty) begin
          state_nxt = S_RED;
        end else if (!sts.err && sts.cnt_is1) begin
          cmd.rd0   = 1'b1;
          state_nxt = S_FIN_RD;
        end else begin
          cmd.set_err = 1'b1;
          state_nxt   = S_FIN_OUT;
        end
      end
      S_FIN_RD: begin
        state_nxt = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.clr_state = 1'b1;
          fin_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/iiee_dp.sv
`default_nettype none
module iiee_dp
  import iiee_pkg::*;
#(
  parameter int OPERAND_DEPTH  = 32,
  parameter int OPERATOR_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         in_char,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_result_value,
  output logic                    out_error
);

  localparam int AW  = $clog2(OPERAND_DEPTH);
  localparam int CW  = $clog2(OPERAND_DEPTH + 1);
  localparam int OAW = $clog2(OPERATOR_DEPTH);
  localparam int OCW = $clog2(OPERATOR_DEPTH + 1);

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [OCW-1:0] opcnt_r, opcnt_nxt;
  logic [31:0]    acc_r, acc_nxt;
  logic           neg_r, neg_nxt;
  cls_t           cls_r, cls_nxt;
  pend_t          pend_r, pend_nxt;
  logic           err_r, err_nxt;
  logic           out_valid_r;

  logic [7:0]  c_r;
  op_t         code_r, op_r;
  logic [31:0] a_r, b_r, res_r, out_value_r;
  logic        out_err_r;

  // serial divider
  logic        busy_r;
  logic [4:0]  step_r;
  logic [31:0] rem_r, dvd_r, mb_r;
  logic        na_r, negq_r, mod_r;
  logic [32:0] r2;
  logic        ge;
  logic [31:0] rem_step, dvd_step;

  logic [31:0] opnd_rdata, opnd_wdata, opnd_val;
  logic [AW-1:0] opnd_waddr, opnd_raddr;
  logic        opnd_we, opnd_re;
  logic [3:0]  opr_rdata;
  logic        opr_we;
  logic [CW-1:0]  cnt_m1, cnt_m2;
  logic [OCW-1:0] opcnt_m1;
  logic        opnd_full, opr_full;

  logic        is_digit;
  logic        pend_match;
  op_t         match_code, fb_code, char_code;
  logic        char_is_op;
  pend_t       char_pend;
  logic [31:0] alu_res;
  logic [4:0]  shamt;

  assign cnt_m1    = cnt_r - CW'(1);
  assign cnt_m2    = cnt_r - CW'(2);
  assign opcnt_m1  = opcnt_r - OCW'(1);
  assign opnd_full = (cnt_r == CW'(OPERAND_DEPTH));
  assign opr_full  = (opcnt_r == OCW'(OPERATOR_DEPTH));
  assign opnd_val  = neg_r ? (32'd0 - acc_r) : acc_r;

  // operand stack
  assign opnd_we    = (cmd.end_opnd && !opnd_full) || cmd.wb;
  assign opnd_waddr = cmd.end_opnd ? cnt_r[AW-1:0] : cnt_m2[AW-1:0];
  assign opnd_wdata = cmd.end_opnd ? opnd_val : res_r;
  assign opnd_re    = cmd.rd_b || cmd.rd_a || cmd.rd0;
  assign opnd_raddr = cmd.rd_b ? cnt_m1[AW-1:0] : (cmd.rd_a ? cnt_m2[AW-1:0] : '0);

  iiee_ram #(.WIDTH(32), .DEPTH(OPERAND_DEPTH)) u_opnd_ram (
    .clk   (clk),
    .we    (opnd_we),
    .waddr (opnd_waddr),
    .wdata (opnd_wdata),
    .re    (opnd_re),
    .raddr (opnd_raddr),
    .rdata (opnd_rdata)
  );

  // operator stack
  assign opr_we = cmd.op_push && !err_r && !opr_full;

  iiee_ram #(.WIDTH(4), .DEPTH(OPERATOR_DEPTH)) u_opr_ram (
    .clk   (clk),
    .we    (opr_we),
    .waddr (opcnt_r[OAW-1:0]),
    .wdata (code_r),
    .re    (cmd.op_rd),
    .raddr (opcnt_m1[OAW-1:0]),
    .rdata (opr_rdata)
  );

  // character decode
  assign is_digit = (c_r >= CH_0) && (c_r <= CH_9);

  always_comb begin
    char_is_op = 1'b1;
    char_code  = OP_OR;
    case (c_r)
      CH_OR:    char_code = OP_OR;
      CH_XOR:   char_code = OP_XOR;
      CH_AND:   char_code = OP_AND;
      CH_PLUS:  char_code = OP_ADD;
      CH_MINUS: char_code = OP_SUB;
      CH_STAR:  char_code = OP_MUL;
      CH_SLASH: char_code = OP_DIV;
      CH_PCT:   char_code = OP_MOD;
      default:  char_is_op = 1'b0;
    endcase
    case (c_r)
      CH_LT:   char_pend = P_LT;
      CH_GT:   char_pend = P_GT;
      CH_EQ:   char_pend = P_EQ;
      CH_BANG: char_pend = P_NE;
      default: char_pend = P_NONE;
    endcase
    pend_match = 1'b1;
    match_code = OP_EQ;
    if (pend_r == P_LT && c_r == CH_LT)      match_code = OP_SHL;
    else if (pend_r == P_LT && c_r == CH_EQ) match_code = OP_LE;
    else if (pend_r == P_GT && c_r == CH_GT) match_code = OP_SHR;
    else if (pend_r == P_GT && c_r == CH_EQ) match_code = OP_GE;
    else if (pend_r == P_EQ && c_r == CH_EQ) match_code = OP_EQ;
    else if (pend_r == P_NE && c_r == CH_EQ) match_code = OP_NE;
    else pend_match = 1'b0;
    fb_code = (pend_r == P_LT) ? OP_LT : OP_GT;
  end

  // combinational operators
  assign shamt = b_r[4:0];
  always_comb begin
    case (op_r)
      OP_OR:   alu_res = a_r | b_r;
      OP_XOR:  alu_res = a_r ^ b_r;
      OP_AND:  alu_res = a_r & b_r;
      OP_EQ:   alu_res = {31'd0, a_r == b_r};
      OP_NE:   alu_res = {31'd0, a_r != b_r};
      OP_LT:   alu_res = {31'd0, $signed(a_r) < $signed(b_r)};
      OP_GT:   alu_res = {31'd0, $signed(a_r) > $signed(b_r)};
      OP_LE:   alu_res = {31'd0, $signed(a_r) <= $signed(b_r)};
      OP_GE:   alu_res = {31'd0, $signed(a_r) >= $signed(b_r)};
      OP_SHL:  alu_res = a_r << shamt;
      OP_SHR:  alu_res = $unsigned($signed(a_r) >>> shamt);
      OP_ADD:  alu_res = a_r + b_r;
      OP_SUB:  alu_res = a_r - b_r;
      OP_MUL:  alu_res = a_r * b_r;
      default: alu_res = '0;
    endcase
  end

  // restoring divide step on magnitudes
  assign r2       = {rem_r, dvd_r[31]};
  assign ge       = (r2 >= {1'b0, mb_r});
  assign rem_step = ge ? 32'(r2 - {1'b0, mb_r}) : r2[31:0];
  assign dvd_step = {dvd_r[30:0], ge};

  // control state next values
  always_comb begin
    cnt_nxt   = cnt_r;
    opcnt_nxt = opcnt_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    cls_nxt   = cls_r;
    pend_nxt  = pend_r;
    err_nxt   = err_r;
    if (cmd.clr_state) begin
      cnt_nxt   = '0;
      opcnt_nxt = '0;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      cls_nxt   = CLS_EXPECT;
      pend_nxt  = P_NONE;
      err_nxt   = 1'b0;
    end else begin
      if (cmd.set_err) err_nxt = 1'b1;
      if (cmd.space_upd && cls_r == CLS_NUM) cls_nxt = CLS_NUMSP;
      if (cmd.accum_upd) begin
        acc_nxt = (acc_r << 3) + (acc_r << 1) + {24'd0, c_r - CH_0};
        cls_nxt = CLS_NUM;
      end
      if (cmd.set_sign) begin
        neg_nxt = (c_r == CH_MINUS);
        cls_nxt = CLS_SIGN;
      end
      if (cmd.set_pend) begin
        pend_nxt = char_pend;
        cls_nxt  = CLS_EXPECT;
      end
      if (cmd.end_opnd) begin
        if (opnd_full) err_nxt = 1'b1;
        else cnt_nxt = cnt_r + CW'(1);
        acc_nxt = '0;
        neg_nxt = 1'b0;
      end
      if (cmd.op_push) begin
        if (!err_r) begin
          if (opr_full) err_nxt = 1'b1;
          else opcnt_nxt = opcnt_r + OCW'(1);
        end
        cls_nxt  = CLS_EXPECT;
        pend_nxt = P_NONE;
      end
      if (cmd.wb) begin
        cnt_nxt   = cnt_m1;
        opcnt_nxt = opcnt_m1;
      end
      if (cmd.div_start && b_r == 32'd0) err_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      opcnt_r     <= '0;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      cls_r       <= CLS_EXPECT;
      pend_r      <= P_NONE;
      err_r       <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      opcnt_r <= opcnt_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      cls_r   <= cls_nxt;
      pend_r  <= pend_nxt;
      err_r   <= err_nxt;
      if (cmd.div_start) busy_r <= (b_r != 32'd0);
      else if (busy_r && step_r == 5'd31) busy_r <= 1'b0;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_char) c_r <= in_char;
    if (cmd.set_code) begin
      case (cmd.code_src)
        CS_MATCH:    code_r <= match_code;
        CS_FALLBACK: code_r <= fb_code;
        default:     code_r <= char_code;
      endcase
    end
    if (cmd.cap_b) begin
      b_r  <= opnd_rdata;
      op_r <= op_t'(opr_rdata);
    end
    if (cmd.cap_a) a_r <= opnd_rdata;
    if (cmd.alu) res_r <= alu_res;
    if (cmd.div_start) begin
      na_r   <= a_r[31];
      negq_r <= a_r[31] ^ b_r[31];
      mod_r  <= (op_r == OP_MOD);
      mb_r   <= b_r[31] ? (32'd0 - b_r) : b_r;
      dvd_r  <= a_r[31] ? (32'd0 - a_r) : a_r;
      rem_r  <= '0;
      step_r <= '0;
      if (b_r == 32'd0) res_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_step;
      dvd_r  <= dvd_step;
      step_r <= step_r + 5'd1;
      if (step_r == 5'd31) begin
        if (mod_r) res_r <= na_r ? (32'd0 - rem_step) : rem_step;
        else res_r <= negq_r ? (32'd0 - dvd_step) : dvd_step;
      end
    end
    if (cmd.out_load) begin
      out_value_r <= err_r ? 32'd0 : opnd_rdata;
      out_err_r   <= err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(out_value_r);
  assign out_error        = out_err_r;

  always_comb begin
    sts.is_hash    = (c_r == CH_HASH);
    sts.is_space   = (c_r == CH_SPACE);
    sts.is_digit   = is_digit;
    sts.is_sign    = (c_r == CH_PLUS) || (c_r == CH_MINUS);
    sts.is_binop   = char_is_op;
    sts.is_cmp1    = (char_pend != P_NONE);
    sts.pend_nz    = (pend_r != P_NONE);
    sts.pend_match = pend_match;
    sts.pend_ltgt  = (pend_r == P_LT) || (pend_r == P_GT);
    sts.cls        = cls_r;
    sts.err        = err_r;
    sts.red_bad    = (cnt_r < CW'(2)) || (opcnt_r == '0);
    sts.opr_empty  = (opcnt_r == '0);
    sts.prec_ge    = (prec_of(op_t'(opr_rdata)) >= prec_of(code_r));
    sts.op_is_div  = (op_r == OP_DIV) || (op_r == OP_MOD);
    sts.div_busy   = busy_r;
    sts.cnt_is1    = (cnt_r == CW'(1));
    sts.out_busy   = out_valid_r && out_stall;
  end

endmodule
`default_nettype wire

>>> src/infix_integer_expression_evaluator.sv
// Streaming C-style integer expression evaluator. Feed one ASCII character per
// transfer on in_char; '#' closes the expression and yields one result transfer
// (out_result_value, out_error), after which the block is clear for the next
// expression. Digits, blanks, a leading sign and the operators
// | ^ & == != < > <= >= << >> + - * / % are understood with C precedence and
// left associativity; 32-bit wrapping arithmetic, out_error set (value 0) on
// bad syntax, divide by zero or a full stack. A digit, sign or first
// character of a comparison is accepted, decoded and acted on; a blank is
// accepted and decoded. A binary operator first reduces while the operator
// on top of the stack binds at least as tightly, then is pushed; a / or %
// reduction waits on the one-bit-per-cycle divider. The terminator reduces
// every pending operator, unless the expression is already in error, and
// then waits for the output register to drain. The operand and operator
// stacks are single-read-port memories, read one entry per cycle, and the
// divider is serial. A new character is taken while a finished result
// still waits on out_stall; only '#' waits for the output register to drain.
`default_nettype none
module infix_integer_expression_evaluator
  import iiee_pkg::*;
#(
  parameter int OPERAND_DEPTH  = 32,
  parameter int OPERATOR_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_char,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_result_value,
  output logic                    out_error
);

  cmd_t cmd;   // controller -> datapath strobes
  sts_t sts;   // datapath flags back to the controller

  iiee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iiee_dp #(
    .OPERAND_DEPTH  (OPERAND_DEPTH),
    .OPERATOR_DEPTH (OPERATOR_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_char          (in_char),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_error        (out_error)
  );

endmodule
`default_nettype wire

>>> src/iiee_checker.sv
`default_nettype none
`include "infix_integer_expression_evaluator_defines.svh"
module iiee_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_result_value,
  input wire logic        out_error
);

  `IIEE_ASSERT_ON(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_result_value) && $stable(out_error), "stalled result changed")
  `IIEE_ASSERT_ON(a_err_zero, out_valid && out_error |-> out_result_value == 32'd0, "error result not zero")
  `IIEE_ASSERT_ALL(a_rst_clear, !rst_n |=> !out_valid && !in_stall, "reset did not clear handshake")
  `IIEE_ASSERT_ON(a_busy_after_in, in_valid && !in_stall |=> in_stall, "input taken without decode cycle")

endmodule

bind infix_integer_expression_evaluator iiee_checker u_iiee_checker (.*);
`default_nettype wire

>>> bench/infix_integer_expression_evaluator_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module infix_integer_expression_evaluator_tb;
  import iiee_pkg::*;

  localparam int OPND_DEPTH = 32;
  localparam int OPR_DEPTH  = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char = 8'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_result_value;
  logic               out_error;

  infix_integer_expression_evaluator #(
    .OPERAND_DEPTH(OPND_DEPTH),
    .OPERATOR_DEPTH(OPR_DEPTH)
  ) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_char(in_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_error(out_error)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Expression evaluator shadow: mirrors the block's state.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic [31:0] value;
    logic        err;
  } eval_res_t;

  logic [31:0] sh_opnd [OPND_DEPTH];
  op_t         sh_opr  [OPR_DEPTH];
  int unsigned sh_opnd_cnt, sh_opr_cnt;
  logic [31:0] sh_accum;
  logic        sh_neg;
  cls_t        sh_cls;
  pend_t       sh_pend;
  logic        sh_err;

  eval_res_t   pending_results[$];
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          errors_seen = 0;
  int          chars_sent = 0;
  bit          hold_off = 1'b0;   // long receiver hold-off requested
  bit          rx_random = 1'b1;  // random receiver stalls enabled

  function automatic int unsigned prec_rank(op_t op);
    case (op)
      OP_OR: return 1;
      OP_XOR: return 2;
      OP_AND: return 3;
      OP_EQ, OP_NE: return 4;
      OP_LT, OP_GT, OP_LE, OP_GE: return 5;
      OP_SHL, OP_SHR: return 6;
      OP_ADD, OP_SUB: return 7;
      default: return 8;
    endcase
  endfunction

  task automatic shadow_clear();
    sh_opnd_cnt = 0;
    sh_opr_cnt = 0;
    sh_accum = '0;
    sh_neg = 1'b0;
    sh_cls = CLS_EXPECT;
    sh_pend = P_NONE;
    sh_err = 1'b0;
  endtask

  function automatic logic [31:0] alu(op_t op, logic [31:0] a, logic [31:0] b);
    logic signed [31:0] sa, sb;
    logic [31:0] ma, mb, q;
    sa = a;
    sb = b;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (op)
      OP_OR:  return a | b;
      OP_XOR: return a ^ b;
      OP_AND: return a & b;
      OP_EQ:  return {31'd0, a == b};
      OP_NE:  return {31'd0, a != b};
      OP_LT:  return {31'd0, sa < sb};
      OP_GT:  return {31'd0, sa > sb};
      OP_LE:  return {31'd0, sa <= sb};
      OP_GE:  return {31'd0, sa >= sb};
      OP_SHL: return a << b[4:0];
      OP_SHR: return sa >>> b[4:0];
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_DIV: begin
        if (b == 0) begin
          sh_err = 1'b1;
          return '0;
        end
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
      end
      default: begin
        if (b == 0) begin
          sh_err = 1'b1;
          return '0;
        end
        q = ma % mb;
        return a[31] ? -q : q;
      end
    endcase
  endfunction

  task automatic shadow_reduce();
    logic [31:0] a, b;
    if (sh_opnd_cnt < 2 || sh_opr_cnt == 0) begin
      sh_err = 1'b1;
      return;
    end
    b = sh_opnd[sh_opnd_cnt-1];
    a = sh_opnd[sh_opnd_cnt-2];
    sh_opr_cnt--;
    sh_opnd[sh_opnd_cnt-2] = alu(sh_opr[sh_opr_cnt], a, b);
    sh_opnd_cnt--;
  endtask

  task automatic shadow_end_operand();
    if (sh_opnd_cnt >= OPND_DEPTH) sh_err = 1'b1;
    else begin
      sh_opnd[sh_opnd_cnt] = sh_neg ? -sh_accum : sh_accum;
      sh_opnd_cnt++;
    end
    sh_accum = '0;
    sh_neg = 1'b0;
  endtask

  task automatic shadow_commit(op_t code);
    while (!sh_err && sh_opr_cnt > 0 && prec_rank(sh_opr[sh_opr_cnt-1]) >= prec_rank(code))
      shadow_reduce();
    if (!sh_err) begin
      if (sh_opr_cnt >= OPR_DEPTH) sh_err = 1'b1;
      else begin
        sh_opr[sh_opr_cnt] = code;
        sh_opr_cnt++;
      end
    end
    sh_cls = CLS_EXPECT;
    sh_pend = P_NONE;
  endtask

  // Feed one character; a '#' queues the expected result.
  task automatic evaluate_char(logic [7:0] c);
    eval_res_t r;
    pend_t p;
    if (c == CH_HASH) begin
      r = '0;
      if (!sh_err) begin
        if (sh_pend != P_NONE || sh_cls == CLS_EXPECT || sh_cls == CLS_SIGN) sh_err = 1'b1;
        else shadow_end_operand();
        while (!sh_err && sh_opr_cnt > 0) shadow_reduce();
        if (!sh_err && sh_opnd_cnt == 1) r.value = sh_opnd[0];
        else sh_err = 1'b1;
      end
      r.err = sh_err;
      if (sh_err) r.value = '0;
      pending_results.push_back(r);
      shadow_clear();
      return;
    end
    if (sh_err) return;
    if (c == CH_SPACE) begin
      if (sh_cls == CLS_NUM) sh_cls = CLS_NUMSP;
      return;
    end
    if (sh_pend != P_NONE) begin
      p = sh_pend;
      if (p == P_LT && c == CH_LT) begin shadow_commit(OP_SHL); return; end
      if (p == P_LT && c == CH_EQ) begin shadow_commit(OP_LE); return; end
      if (p == P_GT && c == CH_GT) begin shadow_commit(OP_SHR); return; end
      if (p == P_GT && c == CH_EQ) begin shadow_commit(OP_GE); return; end
      if (p == P_EQ && c == CH_EQ) begin shadow_commit(OP_EQ); return; end
      if (p == P_NE && c == CH_EQ) begin shadow_commit(OP_NE); return; end
      if (p == P_LT) shadow_commit(OP_LT);
      else if (p == P_GT) shadow_commit(OP_GT);
      else begin
        sh_err = 1'b1;
        return;
      end
      if (sh_err) return;
    end
    if (c >= CH_0 && c <= CH_9) begin
      if (sh_cls == CLS_NUMSP) begin
        sh_err = 1'b1;
        return;
      end
      sh_accum = sh_accum * 10 + 32'(c - CH_0);
      sh_cls = CLS_NUM;
      return;
    end
    if (sh_cls == CLS_EXPECT) begin
      if (c == CH_PLUS || c == CH_MINUS) begin
        sh_neg = (c == CH_MINUS);
        sh_cls = CLS_SIGN;
      end else sh_err = 1'b1;
      return;
    end
    if (sh_cls == CLS_SIGN) begin
      sh_err = 1'b1;
      return;
    end
    case (c)
      CH_OR:    begin shadow_end_operand(); shadow_commit(OP_OR);  end
      CH_XOR:   begin shadow_end_operand(); shadow_commit(OP_XOR); end
      CH_AND:   begin shadow_end_operand(); shadow_commit(OP_AND); end
      CH_PLUS:  begin shadow_end_operand(); shadow_commit(OP_ADD); end
      CH_MINUS: begin shadow_end_operand(); shadow_commit(OP_SUB); end
      CH_STAR:  begin shadow_end_operand(); shadow_commit(OP_MUL); end
      CH_SLASH: begin shadow_end_operand(); shadow_commit(OP_DIV); end
      CH_PCT:   begin shadow_end_operand(); shadow_commit(OP_MOD); end
      CH_LT:    begin shadow_end_operand(); sh_pend = P_LT; sh_cls = CLS_EXPECT; end
      CH_GT:    begin shadow_end_operand(); sh_pend = P_GT; sh_cls = CLS_EXPECT; end
      CH_EQ:    begin shadow_end_operand(); sh_pend = P_EQ; sh_cls = CLS_EXPECT; end
      CH_BANG:  begin shadow_end_operand(); sh_pend = P_NE; sh_cls = CLS_EXPECT; end
      default:  sh_err = 1'b1;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Sender: one character per transfer, driven at the falling edge.
  // Burst/gap shaping keeps valid steady within a burst; valid drops only
  // when a gap is taken.
  // ---------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_char(logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_char  <= c;
    evaluate_char(c);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // ---------------------------------------------------------------------
  // Receiver stall pattern and the long hold-off.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (!rx_random) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) < 3);
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // Result checker: every accepted result against the oldest expectation.
  eval_res_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_result_value, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (want.err) errors_seen++;
        if (out_error !== want.err)
          report_mismatch("error flag", {31'd0, out_error}, {31'd0, want.err});
        if (out_result_value !== want.value)
          report_mismatch("value", out_result_value, want.value);
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Random expression builders
  // ---------------------------------------------------------------------
  function automatic string rand_number();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return "0";
    if (k == 1) return "2147483648";
    if (k == 2) return "4294967295";
    if (k == 3) return $sformatf("%0d", $urandom);
    if (k == 4) return "99999999999";
    return $sformatf("%0d", $urandom_range(0, 40));
  endfunction

  function automatic string rand_operator();
    case ($urandom_range(0, 17))
      0: return "|";   1: return "^";   2: return "&";   3: return "==";
      4: return "!=";  5: return "<";   6: return ">";   7: return "<=";
      8: return ">=";  9: return "<<"; 10: return ">>"; 11: return "+";
      12: return "-"; 13: return "*";  14: return "/";  15: return "%";
      16: return "< =";
      default: return "*";
    endcase
  endfunction

  function automatic string rand_blank();
    return ($urandom_range(0, 4) == 0) ? " " : "";
  endfunction

  function automatic string rand_expression(int terms);
    string s;
    s = "";
    for (int i = 0; i < terms; i++) begin
      if (i > 0) s = {s, rand_blank(), rand_operator(), rand_blank()};
      case ($urandom_range(0, 5))
        0: s = {s, "-"};
        1: s = {s, "+"};
        default: ;
      endcase
      s = {s, rand_number()};
    end
    return {s, rand_blank()};
  endfunction

  // Break an expression by overwriting one character with any byte but '#'.
  function automatic string corrupt(string s);
    int pos;
    byte c;
    if (s.len() == 0) return s;
    pos = $urandom_range(0, s.len() - 1);
    c = byte'($urandom_range(0, 255));
    if (c == CH_HASH) c = 8'd97;
    s[pos] = c;
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    send_text("2147483647+1#");
    send_text("-2147483648/-1#");
    send_text("-2147483648%-1#");
    send_text("7/0#");
    send_text("-7%3#");
    send_text("1|6^3&5==5!=0<2>1<=1>=0<<3>>1+2-1*3#");
    send_text("10-4-3#");
    send_text("-8>>1 # 1<<33#");
    send_text("1 2#");
    send_text("1 < = 2#");
    send_text("3=4#");
    send_text("3!4#");
    send_text("a#");
    send_text("--1#");
    send_text("*2#");
    send_text("1+#");
    send_text("#");
    send_text("4294967296#");
    send_text("1+(2)#");
  endtask

  task automatic test_stack_overflow();
    string s;
    // long chain that breaks on two operators in a row
    s = "1";
    for (int i = 0; i < 17; i++) s = {s, "|1&1^"};
    send_text({s, "1#"});
    // long alternating chain keeps reducing and still evaluates
    s = "";
    for (int i = 0; i < 16; i++) s = {s, "1|2^"};
    send_text({s.substr(0, s.len() - 2), "#"});
  endtask

  task automatic test_every_byte();
    // every byte value as the first character of an expression
    for (int c = 0; c < 256; c++) begin
      if (c != CH_HASH) send_char(8'(c));
      send_char(CH_HASH);
    end
  endtask

  task automatic test_random(int target);
    string s;
    int start;
    start = chars_sent;
    while (chars_sent - start < target) begin
      s = rand_expression($urandom_range(1, 6));
      case ($urandom_range(0, 9))
        0: s = corrupt(s);
        1: s = {s, rand_operator()};
        default: ;
      endcase
      send_text({s, "#"});
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) send_text("12*3-4#");
      end
    join
  endtask

  task automatic test_no_stall();
    rx_random = 1'b0;
    test_random(120);
    rx_random = 1'b1;
  endtask

  initial begin
    int drain;
    shadow_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_stack_overflow();
    test_backpressure();
    test_no_stall();
    test_random(20);
    test_every_byte();

    in_valid <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);

    $display("covered %0d characters, %0d results (%0d flagged as errors)",
             chars_sent, results_seen, errors_seen);
    $display("precedence, two-character operators, long chains, divide by zero, all byte codes");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
